### rtl/block_pool_manager_unit_defines.svh
// ----------------------------------------------------------------------------
// Block pool manager assertion macros
// Shared property templates for the checks inside the block pool manager.
// ----------------------------------------------------------------------------
`ifndef BLOCK_POOL_MANAGER_UNIT_DEFINES_SVH
`define BLOCK_POOL_MANAGER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("block pool manager check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("block pool manager check failed");

`endif

### rtl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// Block pool manager package
// Widths, codes and the interface structs shared by the pool manager modules.
// ----------------------------------------------------------------------------
package bpm_pkg;

   localparam int unsigned NUM_BLOCKS = 256;
   localparam int unsigned ID_W       = $clog2(NUM_BLOCKS);
   localparam int unsigned CNT_W      = ID_W + 1;
   localparam int unsigned BYTES_W    = 40;
   localparam int unsigned BB_W       = 24;
   localparam int unsigned WC_W       = 8;
   localparam int unsigned LEFT_W     = 31;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 40;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 80;
   localparam int unsigned KEEP_W     = BB_W + WC_W + 1;

   // Request kinds; the remaining codes are answered like a query.
   localparam logic [KIND_W-1:0] REQ_GET  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_FREE = 2'd1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BYTES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOFT_LIMIT_ON = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOFT_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_LIMIT_ON = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WORKER_COUNT  = 3'd5;

   localparam logic [BB_W-1:0]   BLOCK_BYTES_RESET  = 24'd4096;
   localparam logic [WC_W-1:0]   WORKER_COUNT_RESET = 8'd1;
   localparam logic [LEFT_W-1:0] LEFT_MAX           = '1;
   localparam logic [LEFT_W-1:0] UNLIMITED_LEFT     = 31'd9999;
   localparam logic [CNT_W-1:0]  KEEP_NO_LIMIT      = 9'd5;

   typedef enum logic [STATUS_W-1:0] {
      ST_GOT_CACHED   = 3'd0,
      ST_GOT_FRESH    = 3'd1,
      ST_HARD_REFUSED = 3'd2,
      ST_POOL_EMPTY   = 3'd3,
      ST_KEPT         = 3'd4,
      ST_RELEASED     = 3'd5,
      ST_NOT_IN_USE   = 3'd6,
      ST_QUERY        = 3'd7
   } status_type;

   // Start of a blocks-left calculation, with the state after the request.
   typedef struct packed {
      logic               start;
      logic [BYTES_W-1:0] alloc;
      logic [CNT_W-1:0]   cache_cnt;
      logic [BB_W-1:0]    blk_bytes;
      logic [BYTES_W-1:0] soft_bytes;
      logic [WC_W-1:0]    workers;
   } left_req_type;

   typedef struct packed {
      logic              done;
      logic [LEFT_W-1:0] left;
   } left_rsp_type;

endpackage

### rtl/bpm_ram.sv
// ----------------------------------------------------------------------------
// Block pool manager RAM
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bpm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bpm_left.sv
// ----------------------------------------------------------------------------
// Block pool manager blocks-left unit
// Works out how many more blocks the soft limit allows, one quotient bit a
// cycle.
// ----------------------------------------------------------------------------
module bpm_left (
   input  logic                  clock,
   input  logic                  reset,
   input  bpm_pkg::left_req_type left_req,
   output bpm_pkg::left_rsp_type left_rsp
);

   import bpm_pkg::*;

   localparam int unsigned CoefW   = CNT_W + 1;
   localparam int unsigned ProdW   = BB_W + 1 + CoefW;
   localparam int unsigned NearW   = BYTES_W + 2;
   localparam int unsigned RoomW   = BYTES_W + 1;
   localparam int unsigned DivCntW = $clog2(LEFT_W);

   typedef enum logic [5:0] {
      L_IDLE = 6'b000001,
      L_MUL  = 6'b000010,
      L_NEAR = 6'b000100,
      L_SAT  = 6'b001000,
      L_DIV  = 6'b010000,
      L_DONE = 6'b100000
   } lstate_type;

   lstate_type              state_ff, state_in;
   logic [BYTES_W-1:0]      alloc_ff, alloc_in;
   logic signed [CoefW-1:0] coef_ff, coef_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic [RoomW-1:0]        room_ff, room_in;
   logic [BB_W-1:0]         rem_ff, rem_in;
   logic [LEFT_W-1:0]       dvd_ff, dvd_in;
   logic [LEFT_W-1:0]       left_ff, left_in;
   logic [DivCntW-1:0]      cnt_ff, cnt_in;

   logic signed [NearW-1:0] near;
   logic signed [NearW-1:0] soft_ext;
   logic [BB_W:0]           trial;
   logic                    trial_ge;

   always_comb begin
      // Signed distance of (workers / 2) from the number of cached ids.
      coef_in = signed'({3'b000, left_req.workers[WC_W-1:1]})
              - signed'({1'b0, left_req.cache_cnt});
      prod_in = ProdW'(signed'({1'b0, left_req.blk_bytes}) * coef_ff);

      near     = signed'({2'b00, alloc_ff}) + NearW'(prod_ff);
      soft_ext = signed'({2'b00, left_req.soft_bytes});
      room_in  = RoomW'(soft_ext - near);

      trial    = {rem_ff, dvd_ff[LEFT_W-1]};
      trial_ge = trial >= {1'b0, left_req.blk_bytes};
   end

   always_comb begin
      state_in = state_ff;
      alloc_in = alloc_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      left_in  = left_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         L_IDLE: begin
            alloc_in = left_req.alloc;
            if (left_req.start) begin
               state_in = L_MUL;
            end
         end
         L_MUL: begin
            state_in = L_NEAR;
         end
         L_NEAR: begin
            if (near > soft_ext) begin
               left_in  = '0;
               state_in = L_DONE;
            end else begin
               state_in = L_SAT;
            end
         end
         L_SAT: begin
            // A zero block size also lands here, since any room is at least zero.
            if ({14'b0, room_ff} >= {left_req.blk_bytes, LEFT_W'(0)}) begin
               left_in  = LEFT_MAX;
               state_in = L_DONE;
            end else begin
               rem_in   = BB_W'(room_ff[RoomW-1:LEFT_W]);
               dvd_in   = room_ff[LEFT_W-1:0];
               left_in  = '0;
               cnt_in   = '0;
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            rem_in  = trial_ge ? BB_W'(trial - {1'b0, left_req.blk_bytes}) : BB_W'(trial);
            dvd_in  = {dvd_ff[LEFT_W-2:0], 1'b0};
            left_in = {left_ff[LEFT_W-2:0], trial_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DivCntW'(LEFT_W - 1)) begin
               state_in = L_DONE;
            end
         end
         L_DONE: begin
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      alloc_ff <= alloc_in;
      coef_ff  <= coef_in;
      prod_ff  <= prod_in;
      room_ff  <= room_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      left_ff  <= left_in;
      cnt_ff   <= cnt_in;
   end

   assign left_rsp.done = (state_ff == L_DONE);
   assign left_rsp.left = left_ff;

endmodule

### rtl/block_pool_manager_unit.sv
// ----------------------------------------------------------------------------
// Block pool manager
// Hands out equal-sized blocks by id from a cache or a spare stack, takes
// them back, and reports how many more blocks the soft limit allows.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Contents
// req_      in         tvalid / tready    tuser: request kind; tdata: block id
// rsp_      out        tvalid / tready    tuser: status; tdata: result fields
// csr_      in         valid / ready      index and data of one register
//
// While the soft limit is off, an accepted request first reads the stack and
// in-use memories, then modifies and writes them back before the next
// acceptance. With the soft limit on, every response also carries a
// blocks-left figure produced by a bit-serial divider, which holds a request
// through a multiply, a compare, a saturation check and 31 quotient
// steps. Reset is synchronous and needs no clearing pass: the spare stack
// uses a low-water mark and the in-use map a valid bit per id. A stalled
// response only holds the block when a second response is ready behind it.
//
`include "block_pool_manager_unit_defines.svh"

module block_pool_manager_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tuser: req_type [1:0]
   input  logic [bpm_pkg::KIND_W-1:0]         req_tuser,
   // tdata: block_id [7:0]
   input  logic [bpm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tuser: status [2:0]
   output logic [bpm_pkg::STATUS_W-1:0]       rsp_tuser,
   // tdata: granted_block [7:0], blocks_left [38:8], more_allowed [39],
   //        allocated_now [79:40]
   output logic [bpm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpm_pkg::CSR_DATA_W-1:0]     csr_data
);

   import bpm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_LEFT = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [BB_W-1:0]    blk_bytes_ff;
   logic               soft_on_ff;
   logic [BYTES_W-1:0] soft_bytes_ff;
   logic               hard_on_ff;
   logic [BYTES_W-1:0] hard_bytes_ff;
   logic [WC_W-1:0]    workers_ff;

   // Pool state kept in flip-flops.
   logic [CNT_W-1:0]      cache_cnt_ff, cache_cnt_in;
   logic [CNT_W-1:0]      spare_cnt_ff, spare_cnt_in;
   logic [CNT_W-1:0]      spare_low_ff, spare_low_in;
   logic [BYTES_W-1:0]    alloc_ff, alloc_in;
   logic [NUM_BLOCKS-1:0] inuse_vld_ff;

   // Request held between the read and the write-back cycle.
   logic [KIND_W-1:0] req_type_ff;
   logic [ID_W-1:0]   req_id_ff;
   logic [KEEP_W-1:0] keep_prod_ff, keep_prod_in;

   // Result waiting for its blocks-left figure.
   status_type      res_status_ff;
   logic [ID_W-1:0] res_granted_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_granted_ff, rsp_granted_in;
   logic [LEFT_W-1:0]  rsp_left_ff, rsp_left_in;
   logic               rsp_more_ff, rsp_more_in;
   logic [BYTES_W-1:0] rsp_alloc_ff, rsp_alloc_in;

   logic req_accept;
   logic in_exec;
   logic out_free;
   logic load_direct;
   logic load_late;

   // Memory ports.
   logic [ID_W-1:0] stack_raddr;
   logic [ID_W-1:0] stack_rdata;
   logic            stack_we;
   logic [ID_W-1:0] stack_waddr;
   logic            inuse_rdata;
   logic            inuse_we;
   logic [ID_W-1:0] inuse_waddr;
   logic            inuse_wdata;

   // Write-back decision.
   logic             hard_block;
   logic [BYTES_W:0] sum_bytes;
   logic [BYTES_W-1:0] alloc_up;
   logic [BYTES_W-1:0] alloc_down;
   logic [ID_W-1:0]  spare_idx;
   logic [ID_W-1:0]  fresh_id;
   logic             id_in_use;
   logic [BYTES_W:0] keep_limit;
   logic             drop_id;
   status_type       ex_status;
   logic [ID_W-1:0]  ex_granted;

   left_req_type left_req;
   left_rsp_type left_rsp;

   logic [CNT_W:0] pool_total;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign in_exec    = (state_ff == S_EXEC);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_bytes_ff  <= BLOCK_BYTES_RESET;
         soft_on_ff    <= 1'b0;
         soft_bytes_ff <= '0;
         hard_on_ff    <= 1'b0;
         hard_bytes_ff <= '0;
         workers_ff    <= WORKER_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BLOCK_BYTES:   blk_bytes_ff  <= csr_data[BB_W-1:0];
            REG_SOFT_LIMIT_ON: soft_on_ff    <= csr_data[0];
            REG_SOFT_LIMIT:    soft_bytes_ff <= csr_data[BYTES_W-1:0];
            REG_HARD_LIMIT_ON: hard_on_ff    <= csr_data[0];
            REG_HARD_LIMIT:    hard_bytes_ff <= csr_data[BYTES_W-1:0];
            REG_WORKER_COUNT:  workers_ff    <= csr_data[WC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Memories. One stack RAM holds both stacks: the spare stack grows up
   // from entry 0, and the cache stack grows down from the top entry, so
   // cached id number i sits at entry NUM_BLOCKS-1-i. Every id is in one
   // of the two stacks or in use, so the two never meet.
   // ------------------------------------------------------------------
   assign stack_raddr = (cache_cnt_ff != '0) ? ID_W'(CNT_W'(NUM_BLOCKS) - cache_cnt_ff)
                                              : ID_W'(spare_cnt_ff - 1'b1);

   bpm_ram #(
      .WIDTH (ID_W),
      .DEPTH (NUM_BLOCKS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (req_id_ff),
      .rd_en   (req_accept),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   bpm_ram #(
      .WIDTH (1),
      .DEPTH (NUM_BLOCKS)
   ) u_inuse_ram (
      .clock   (clock),
      .wr_en   (inuse_we),
      .wr_addr (inuse_waddr),
      .wr_data (inuse_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[ID_W-1:0]),
      .rd_data (inuse_rdata)
   );

   // ------------------------------------------------------------------
   // Read-modify-write of one request. The reads were issued when the
   // request was accepted; the writes land at the end of the exec cycle,
   // before the next request can read, so no forwarding is needed.
   // ------------------------------------------------------------------
   assign keep_prod_in = KEEP_W'(blk_bytes_ff * (WC_W + 1)'({1'b0, workers_ff} + 1'b1));

   always_comb begin
      hard_block = hard_on_ff && (alloc_ff >= hard_bytes_ff);
      sum_bytes  = {1'b0, alloc_ff} + (BYTES_W + 1)'(blk_bytes_ff);
      alloc_up   = sum_bytes[BYTES_W] ? '1 : sum_bytes[BYTES_W-1:0];
      alloc_down = (alloc_ff >= BYTES_W'(blk_bytes_ff)) ? alloc_ff - BYTES_W'(blk_bytes_ff)
                                                        : '0;

      // Spare entries below the low-water mark were never written since
      // reset; their id is worked out from the index, not read from the RAM.
      spare_idx = ID_W'(spare_cnt_ff - 1'b1);
      fresh_id  = ({1'b0, spare_idx} < spare_low_ff) ? ID_W'(NUM_BLOCKS - 1) - spare_idx
                                                      : stack_rdata;

      id_in_use  = inuse_vld_ff[req_id_ff] && inuse_rdata;
      keep_limit = {1'b0, soft_bytes_ff} + (BYTES_W + 1)'(keep_prod_ff);
      drop_id    = soft_on_ff ? ({1'b0, alloc_ff} > keep_limit)
                              : (cache_cnt_ff > KEEP_NO_LIMIT);

      ex_status    = ST_QUERY;
      ex_granted   = '0;
      cache_cnt_in = cache_cnt_ff;
      spare_cnt_in = spare_cnt_ff;
      spare_low_in = spare_low_ff;
      alloc_in     = alloc_ff;
      stack_we     = 1'b0;
      stack_waddr  = spare_cnt_ff[ID_W-1:0];
      inuse_we     = 1'b0;
      inuse_waddr  = req_id_ff;
      inuse_wdata  = 1'b0;

      unique case (req_type_ff)
         REQ_GET: begin
            inuse_wdata = 1'b1;
            if (hard_block) begin
               ex_status = ST_HARD_REFUSED;
            end else if (cache_cnt_ff != '0) begin
               ex_status    = ST_GOT_CACHED;
               ex_granted   = stack_rdata;
               cache_cnt_in = cache_cnt_ff - 1'b1;
               inuse_we     = 1'b1;
               inuse_waddr  = stack_rdata;
            end else if (spare_cnt_ff != '0) begin
               ex_status    = ST_GOT_FRESH;
               ex_granted   = fresh_id;
               spare_cnt_in = spare_cnt_ff - 1'b1;
               if ({1'b0, spare_idx} < spare_low_ff) begin
                  spare_low_in = {1'b0, spare_idx};
               end
               alloc_in    = alloc_up;
               inuse_we    = 1'b1;
               inuse_waddr = fresh_id;
            end else begin
               ex_status = ST_POOL_EMPTY;
            end
         end
         REQ_FREE: begin
            if (!id_in_use) begin
               ex_status = ST_NOT_IN_USE;
            end else begin
               inuse_we = 1'b1;
               if (drop_id || (cache_cnt_ff >= CNT_W'(NUM_BLOCKS))) begin
                  ex_status = ST_RELEASED;
                  if (spare_cnt_ff < CNT_W'(NUM_BLOCKS)) begin
                     stack_we     = 1'b1;
                     spare_cnt_in = spare_cnt_ff + 1'b1;
                  end
                  alloc_in = alloc_down;
               end else begin
                  ex_status    = ST_KEPT;
                  stack_we     = 1'b1;
                  stack_waddr  = ID_W'(CNT_W'(NUM_BLOCKS - 1) - cache_cnt_ff);
                  cache_cnt_in = cache_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            ex_status = ST_QUERY;
         end
      endcase

      // Nothing commits outside the exec cycle.
      if (!in_exec) begin
         stack_we = 1'b0;
         inuse_we = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Blocks-left unit, started with the state after the request. The user
   // must not change configuration while it runs; the block does not enforce it.
   // ------------------------------------------------------------------
   assign left_req.start      = in_exec && soft_on_ff;
   assign left_req.alloc      = alloc_in;
   assign left_req.cache_cnt  = cache_cnt_in;
   assign left_req.blk_bytes  = blk_bytes_ff;
   assign left_req.soft_bytes = soft_bytes_ff;
   assign left_req.workers    = workers_ff;

   bpm_left u_left (
      .clock    (clock),
      .reset    (reset),
      .left_req (left_req),
      .left_rsp (left_rsp)
   );

   // ------------------------------------------------------------------
   // Sequencer and output register.
   // ------------------------------------------------------------------
   assign load_direct = in_exec && !soft_on_ff && out_free;
   assign load_late   = (state_ff == S_OUT) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (soft_on_ff) begin
               state_in = S_LEFT;
            end else if (out_free) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_LEFT: begin
            if (left_rsp.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_more_in    = rsp_more_ff;
      rsp_alloc_in   = rsp_alloc_ff;
      if (load_direct) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = ex_status;
         rsp_granted_in = ex_granted;
         rsp_left_in    = UNLIMITED_LEFT;
         rsp_more_in    = 1'b1;
         rsp_alloc_in   = alloc_in;
      end else if (load_late) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status_ff;
         rsp_granted_in = res_granted_ff;
         rsp_left_in    = soft_on_ff ? left_rsp.left : UNLIMITED_LEFT;
         rsp_more_in    = !soft_on_ff || (left_rsp.left != '0);
         rsp_alloc_in   = alloc_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cache_cnt_ff <= '0;
         spare_cnt_ff <= CNT_W'(NUM_BLOCKS);
         spare_low_ff <= CNT_W'(NUM_BLOCKS);
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_exec) begin
            cache_cnt_ff <= cache_cnt_in;
            spare_cnt_ff <= spare_cnt_in;
            spare_low_ff <= spare_low_in;
            alloc_ff     <= alloc_in;
         end
      end
   end

   // An id whose valid bit is clear reads as not in use.
   always_ff @(posedge clock) begin
      if (reset) begin
         inuse_vld_ff <= '0;
      end else if (inuse_we) begin
         inuse_vld_ff[inuse_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_type_ff  <= req_tuser;
         req_id_ff    <= req_tdata[ID_W-1:0];
         keep_prod_ff <= keep_prod_in;
      end
      if (in_exec) begin
         res_status_ff  <= ex_status;
         res_granted_ff <= ex_granted;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_more_ff    <= rsp_more_in;
      rsp_alloc_ff   <= rsp_alloc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_alloc_ff, rsp_more_ff, rsp_left_ff, rsp_granted_ff};

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   assign pool_total = {1'b0, cache_cnt_ff} + {1'b0, spare_cnt_ff};

   `BPM_ASSERT_IMP(a_pool_bounded, 1'b1, pool_total <= (CNT_W + 1)'(NUM_BLOCKS))
   `BPM_ASSERT_IMP(a_low_mark_below_top, 1'b1, spare_low_ff <= spare_cnt_ff)
   `BPM_ASSERT_NXT(a_single_commit, state_ff == S_EXEC, state_ff != S_EXEC)
   `BPM_ASSERT_IMP(a_left_done_expected, left_rsp.done, state_ff == S_LEFT)

endmodule

### tb/tb_block_pool_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool manager testbench
// Drives get, free and query requests through the block pool manager. Pool
// settings change between phases while the block is idle. A scoreboard
// tracks the cache stack, the spare stack, the in-use map and the allocated
// byte count, and checks every response field against its own prediction.
// ----------------------------------------------------------------------------
module tb_block_pool_manager_unit;
   import bpm_pkg::*;

   // Request kinds beyond the two named in the package. Code 3 has no meaning
   // of its own and must be answered like a query.
   localparam logic [KIND_W-1:0] REQ_QUERY   = 2'd2;
   localparam logic [KIND_W-1:0] REQ_UNKNOWN = 2'd3;

   // Register indexes with no register behind them; writes must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   localparam logic [BB_W-1:0]    BLOCK_BYTES_MAX = '1;
   localparam logic [BYTES_W-1:0] BYTES_MAX       = '1;
   localparam logic [WC_W-1:0]    WORKERS_MAX     = '1;

   // One predicted response, split into its fields.
   typedef struct {
      status_type         status;
      logic [ID_W-1:0]    granted;
      logic [LEFT_W-1:0]  left;
      logic               more;
      logic [BYTES_W-1:0] alloc;
   } pool_result_type;

   // The scoreboard holds its own copy of the pool: the settings, both id
   // stacks, the in-use map and the allocated byte count. Each accepted
   // request updates that copy and queues the response it must produce.
   class pool_scoreboard;
      bit [BB_W-1:0]    blk_bytes;
      bit               soft_on;
      bit [BYTES_W-1:0] soft_bytes;
      bit               hard_on;
      bit [BYTES_W-1:0] hard_bytes;
      bit [WC_W-1:0]    workers;

      bit [ID_W-1:0]    cache_ids [NUM_BLOCKS];
      int               cache_cnt;
      bit [ID_W-1:0]    spare_ids [NUM_BLOCKS];
      int               spare_cnt;
      bit               in_use [NUM_BLOCKS];
      bit [BYTES_W-1:0] alloc_bytes;

      pool_result_type  pending_results [$];
      int               error_count;

      function new();
         blk_bytes   = BLOCK_BYTES_RESET;
         soft_on     = 1'b0;
         soft_bytes  = '0;
         hard_on     = 1'b0;
         hard_bytes  = '0;
         workers     = WORKER_COUNT_RESET;
         cache_cnt   = 0;
         spare_cnt   = NUM_BLOCKS;
         alloc_bytes = '0;
         error_count = 0;
         // The spare stack pops from the top, so id 0 comes out first.
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            spare_ids[i] = ID_W'(NUM_BLOCKS - 1 - i);
            in_use[i]    = 1'b0;
            cache_ids[i] = '0;
         end
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_BLOCK_BYTES:   blk_bytes  = value[BB_W-1:0];
            REG_SOFT_LIMIT_ON: soft_on    = value[0];
            REG_SOFT_LIMIT:    soft_bytes = value[BYTES_W-1:0];
            REG_HARD_LIMIT_ON: hard_on    = value[0];
            REG_HARD_LIMIT:    hard_bytes = value[BYTES_W-1:0];
            REG_WORKER_COUNT:  workers    = value[WC_W-1:0];
            default: ;
         endcase
      endfunction

      // Blocks the soft limit still allows. The estimate counts half the
      // workers as about to take a block and the cached ids as already paid
      // for, so it can go negative and must be worked out signed.
      function logic [LEFT_W-1:0] blocks_left();
         longint alloc_l, bb_l, soft_l, near_bytes, quot;
         if (!soft_on)
            return UNLIMITED_LEFT;
         alloc_l    = alloc_bytes;
         bb_l       = blk_bytes;
         soft_l     = soft_bytes;
         near_bytes = alloc_l + bb_l * (longint'(workers >> 1) - longint'(cache_cnt));
         if (near_bytes > soft_l)
            return '0;
         if (bb_l == 0)
            return LEFT_MAX;
         quot = (soft_l - near_bytes) / bb_l;
         if (quot > longint'(LEFT_MAX))
            return LEFT_MAX;
         return LEFT_W'(quot);
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
         pool_result_type r;
         bit              release_it;
         bit [63:0]       sum;
         bit [63:0]       keep_bytes;
         r.granted = '0;
         if (kind == REQ_GET) begin
            if (hard_on && alloc_bytes >= hard_bytes) begin
               r.status = ST_HARD_REFUSED;
            end else if (cache_cnt > 0) begin
               // A cached id is already counted in the allocated bytes.
               cache_cnt--;
               r.granted         = cache_ids[cache_cnt];
               in_use[r.granted] = 1'b1;
               r.status          = ST_GOT_CACHED;
            end else if (spare_cnt > 0) begin
               spare_cnt--;
               r.granted         = spare_ids[spare_cnt];
               in_use[r.granted] = 1'b1;
               sum               = 64'(alloc_bytes) + 64'(blk_bytes);
               alloc_bytes       = (sum[63:BYTES_W] != 0) ? BYTES_MAX : sum[BYTES_W-1:0];
               r.status          = ST_GOT_FRESH;
            end else begin
               r.status = ST_POOL_EMPTY;
            end
         end else if (kind == REQ_FREE) begin
            if (!in_use[id]) begin
               r.status = ST_NOT_IN_USE;
            end else begin
               in_use[id] = 1'b0;
               keep_bytes = 64'(soft_bytes) + 64'(blk_bytes) * (64'(workers) + 64'd1);
               if (soft_on)
                  release_it = 64'(alloc_bytes) > keep_bytes;
               else
                  release_it = cache_cnt > int'(KEEP_NO_LIMIT);
               if (release_it || cache_cnt >= NUM_BLOCKS) begin
                  if (spare_cnt < NUM_BLOCKS) begin
                     spare_ids[spare_cnt] = id;
                     spare_cnt++;
                  end
                  // The block size may have grown since this id was taken.
                  alloc_bytes = (alloc_bytes >= blk_bytes) ? alloc_bytes - blk_bytes : '0;
                  r.status    = ST_RELEASED;
               end else begin
                  cache_ids[cache_cnt] = id;
                  cache_cnt++;
                  r.status = ST_KEPT;
               end
            end
         end else begin
            r.status = ST_QUERY;
         end
         r.left  = blocks_left();
         r.more  = !soft_on || (r.left != 0);
         r.alloc = alloc_bytes;
         pending_results = {pending_results, r};
      endfunction

      function void compare_field(string name, logic [BYTES_W-1:0] exp_v,
                                  logic [BYTES_W-1:0] act_v);
         if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [RSP_DATA_W-1:0] data);
         pool_result_type exp_r;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: response with no request outstanding, expected none, actual status %0h",
                     $time, status);
            return;
         end
         exp_r = pending_results.pop_front();
         compare_field("status", exp_r.status, status);
         compare_field("granted_block", exp_r.granted, data[7:0]);
         compare_field("blocks_left", exp_r.left, data[38:8]);
         compare_field("more_allowed", exp_r.more, data[39]);
         compare_field("allocated_now", exp_r.alloc, data[79:40]);
      endfunction

      // A random id that is currently handed out, or -1 when none is.
      function int pick_in_use();
         int ids [$];
         for (int i = 0; i < NUM_BLOCKS; i++)
            if (in_use[i])
               ids = {ids, i};
         if (ids.size() == 0)
            return -1;
         return ids[$urandom_range(ids.size() - 1)];
      endfunction
   endclass

   // The receiver switches between these stall patterns every so often.
   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   pool_scoreboard pool_sb;

   // Sender burst state: requests left in this burst.
   int burst_left = 1;

   // Receiver stall state.
   rx_mode_type stall_mode = RX_OPEN;
   int          stall_left = 0;
   logic [7:0]  stall_mask = 8'h01;

   block_pool_manager_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver runs one stall pattern for a random stretch, then picks
   // another. The open pattern gives stretches with no stalls at all.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = rx_mode_type'($urandom_range(3));
         stall_left = $urandom_range(20, 200);
         stall_mask = 8'($urandom_range(1, 255));
      end
      stall_left--;
      stall_mask = {stall_mask[6:0], stall_mask[7]};
      case (stall_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(1));
         RX_SPARSE: rsp_tready <= ($urandom_range(3) == 0);
         default:   rsp_tready <= stall_mask[0];
      endcase
   end

   // Every accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         pool_sb.check_response(rsp_tuser, rsp_tdata);
   end

   // Presents one request and waits until the block takes it. The valid
   // stays high across a burst; at the end of a burst the sender may pause.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
      int gap_len;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= id;
      do
         @(posedge clock);
      while (!req_tready);
      pool_sb.note_request(kind, id);
      burst_left--;
      if (burst_left <= 0) begin
         gap_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      end
   endtask

   // Frees an id that is handed out right now, so the free takes effect; id 0 when none is.
   task automatic free_some_block();
      int pick;
      pick = pool_sb.pick_in_use();
      send_request(REQ_FREE, (pick < 0) ? ID_W'(0) : ID_W'(pick));
   endtask

   // A random request. Most frees name an id in use, a few name any id.
   task automatic random_request(int get_pct);
      int rest, share;
      rest  = $urandom_range(99);
      share = 100 - get_pct;
      if (rest < get_pct) begin
         send_request(REQ_GET, ID_W'($urandom));
      end else begin
         rest = rest - get_pct;
         if (rest < share * 60 / 100)
            free_some_block();
         else if (rest < share * 75 / 100)
            send_request(REQ_FREE, ID_W'($urandom));
         else if (rest < share * 92 / 100)
            send_request(REQ_QUERY, ID_W'($urandom));
         else
            send_request(REQ_UNKNOWN, ID_W'($urandom));
      end
   endtask

   // Lowers the request valid and waits until every response is back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pool_sb.pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Writes one register. The valid stays high for a following write and is
   // lowered by csr_done once the group of writes is over.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      pool_sb.write_register(idx, value);
   endtask

   task automatic csr_done();
      csr_valid <= 1'b0;
   endtask

   // Puts random bits above a register's width half of the time; the block
   // must ignore them.
   function automatic logic [CSR_DATA_W-1:0] with_junk(logic [CSR_DATA_W-1:0] value, int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'({$urandom, $urandom});
      return ($urandom_range(1) == 1) ? ((junk << width) | value) : value;
   endfunction

   // Picks a fresh setting for every register, with the extremes weighted in.
   // A drain phase turns both limits off so the pool can run dry.
   task automatic random_settings(bit drain);
      logic [BB_W-1:0]    bb;
      logic [BYTES_W-1:0] soft_v, hard_v;
      logic [WC_W-1:0]    wc;
      logic [63:0]        scaled;
      case ($urandom_range(9))
         0:       bb = 24'd1;
         1:       bb = BLOCK_BYTES_MAX;
         2:       bb = drain ? 24'd1 : 24'd0;
         3, 4, 5: bb = BB_W'($urandom_range(1, 4096));
         6, 7:    bb = BB_W'($urandom_range(1, 65536));
         default: bb = BB_W'($urandom);
      endcase
      scaled = 64'(bb) * 64'($urandom_range(0, 300));
      case ($urandom_range(5))
         0:       soft_v = '0;
         1:       soft_v = BYTES_MAX;
         2, 3:    soft_v = scaled[BYTES_W-1:0];
         4:       soft_v = BYTES_W'({$urandom, $urandom});
         default: soft_v = BYTES_W'($urandom);
      endcase
      scaled = 64'(bb) * 64'($urandom_range(0, 300));
      case ($urandom_range(4))
         0:       hard_v = '0;
         1:       hard_v = BYTES_MAX;
         2, 3:    hard_v = scaled[BYTES_W-1:0];
         default: hard_v = BYTES_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(5))
         0:       wc = 8'd1;
         1:       wc = WORKERS_MAX;
         2:       wc = 8'd0;
         default: wc = WC_W'($urandom_range(1, 255));
      endcase
      csr_write(REG_BLOCK_BYTES, with_junk(CSR_DATA_W'(bb), BB_W));
      csr_write(REG_SOFT_LIMIT_ON, with_junk(drain ? '0 : CSR_DATA_W'($urandom_range(1)), 1));
      csr_write(REG_SOFT_LIMIT, soft_v);
      csr_write(REG_HARD_LIMIT_ON,
                with_junk((drain || $urandom_range(3) != 0) ? '0 : CSR_DATA_W'(1), 1));
      csr_write(REG_HARD_LIMIT, hard_v);
      csr_write(REG_WORKER_COUNT, with_junk(CSR_DATA_W'(wc), WC_W));
      csr_done();
   endtask

   // Watchdog: a hung handshake or a response that never comes ends here.
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      bit drain;
      pool_sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: no soft limit, no hard limit. Query and the unknown
      // kind, fresh gets, a free of an id never handed out, a free that is
      // kept, a second free of the same id, and a get from the cache.
      send_request(REQ_QUERY, 8'h00);
      send_request(REQ_UNKNOWN, 8'hFF);
      send_request(REQ_GET, 8'h00);
      send_request(REQ_GET, 8'hAA);
      send_request(REQ_GET, 8'h55);
      send_request(REQ_FREE, 8'hFF);
      send_request(REQ_FREE, 8'h00);
      send_request(REQ_FREE, 8'h00);
      send_request(REQ_GET, 8'h00);
      free_some_block();

      // Tiny blocks against the largest soft limit: the quotient overflows
      // the blocks-left field and must saturate. Writes to the unused
      // indexes must change nothing.
      wait_idle();
      csr_write(REG_BLOCK_BYTES, CSR_DATA_W'(1));
      csr_write(REG_SOFT_LIMIT_ON, CSR_DATA_W'(1));
      csr_write(REG_SOFT_LIMIT, CSR_DATA_W'(BYTES_MAX));
      csr_write(REG_WORKER_COUNT, CSR_DATA_W'(WORKERS_MAX));
      csr_write(REG_UNUSED_LO, '1);
      csr_write(REG_UNUSED_HI, '1);
      csr_done();
      send_request(REQ_QUERY, 8'h00);
      send_request(REQ_GET, 8'h00);

      // Zero block size: byte counts stay put and blocks left saturate.
      wait_idle();
      csr_write(REG_BLOCK_BYTES, '0);
      csr_done();
      send_request(REQ_GET, 8'h00);
      free_some_block();
      send_request(REQ_QUERY, 8'h00);

      // Hard limit of zero refuses every get.
      wait_idle();
      csr_write(REG_HARD_LIMIT_ON, CSR_DATA_W'(1));
      csr_write(REG_HARD_LIMIT, '0);
      csr_done();
      send_request(REQ_GET, 8'h00);

      // Largest blocks, zero soft limit and no workers: nothing more fits.
      wait_idle();
      csr_write(REG_HARD_LIMIT, CSR_DATA_W'(BYTES_MAX));
      csr_write(REG_BLOCK_BYTES, CSR_DATA_W'(BLOCK_BYTES_MAX));
      csr_write(REG_SOFT_LIMIT, '0);
      csr_write(REG_WORKER_COUNT, '0);
      csr_done();
      send_request(REQ_GET, 8'h00);
      send_request(REQ_QUERY, 8'h00);
      free_some_block();

      // Limits off with the largest blocks: the cache is below the keep count,
      // so the freed ids are kept and the byte count does not change.
      wait_idle();
      csr_write(REG_SOFT_LIMIT_ON, '0);
      csr_write(REG_HARD_LIMIT_ON, '0);
      csr_done();
      repeat (4) free_some_block();

      // Random phases. One of them is get-heavy with both limits off, so
      // the cache and the spare stack both run dry.
      for (int phase = 0; phase < 12; phase++) begin
         drain = (phase == 4);
         wait_idle();
         random_settings(drain);
         repeat (drain ? 420 : 140) random_request(drain ? 85 : 35);
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (pool_sb.error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
